/* src/rilb_pkg.sv */
// Package for the request issue limiter: operation codes, register map,
// stream field layout and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package rilb_pkg;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_RESPONSE = 2'd1;
    localparam logic [1:0] OP_RETRY    = 2'd2;
    localparam logic [1:0] OP_LOAD     = 2'd3;

    localparam logic [1:0] REG_TOTAL    = 2'd0;
    localparam logic [1:0] REG_DEPTH    = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;
    localparam logic [1:0] REG_GROUPS   = 2'd3;

    localparam int ADDR_W    = 4;
    localparam int GCOUNT_W  = 7;
    localparam int SLOT_W    = 6;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic capture;
        logic exec;
        logic adv;
    } rilb_cmd_t;

    typedef struct packed {
        logic out_free;
        logic adv_after_exec;
        logic adv_again;
    } rilb_status_t;

endpackage

`default_nettype wire

/* src/request_issue_limiter_with_barriers.sv */
// Each request is captured, then executed against the group end read from the
// table. A response that moves the barrier past fully retired groups holds off
// the next request while the groups are walked, one table read and one compare
// per group. The result register lets the next request enter while a result
// waits. Configuration registers sit on the APB port at byte addresses 0, 4,
// 8, 12: total_requests, depth_limit, tick_interval, group_count. The group
// end table has no reset; load every group in use.
//
// Top level: APB register file plus rilb_ctrl and rilb_dp; uses rilb_pkg.
`default_nettype none

module request_issue_limiter_with_barriers
    import rilb_pkg::*;
#(
    parameter int MAX_GROUPS = 64
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    // downstream_accept[0], group_slot[6:1], group_end[38:7], zero[39]
    input  wire [IN_DATA_W-1:0]   s_tdata,
    // operation[1:0]
    input  wire [1:0]             s_tuser,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    // send_valid[0], send_index[32:1], stalled[33], outstanding_count[49:34],
    // all_done[50], underflow_error[51], zero[55:52]
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire [ADDR_W-1:0]      paddr,
    input  wire [31:0]            pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [31:0]          total_reg;
    logic [15:0]          depth_reg;
    logic [15:0]          interval_reg;
    logic [GCOUNT_W-1:0]  groups_reg;
    logic                 wr_en;
    rilb_cmd_t            cmd;
    rilb_status_t         sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= '0;
            depth_reg    <= '0;
            interval_reg <= '0;
            groups_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_TOTAL:    total_reg    <= pwdata;
                REG_DEPTH:    depth_reg    <= pwdata[15:0];
                REG_INTERVAL: interval_reg <= pwdata[15:0];
                REG_GROUPS:   groups_reg   <= pwdata[GCOUNT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TOTAL:    prdata = total_reg;
            REG_DEPTH:    prdata = {16'd0, depth_reg};
            REG_INTERVAL: prdata = {16'd0, interval_reg};
            REG_GROUPS:   prdata = {{(32-GCOUNT_W){1'b0}}, groups_reg};
            default:      prdata = '0;
        endcase
    end

    rilb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rilb_dp #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .total_requests (total_reg),
        .depth_limit    (depth_reg),
        .tick_interval  (interval_reg),
        .group_count    (groups_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule

`default_nettype wire

/* src/rilb_ctrl.sv */
// Controller state machine: takes requests in, sequences execution and the
// barrier group advance walk. Uses rilb_pkg.
`default_nettype none

module rilb_ctrl
    import rilb_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire rilb_status_t sts,
    output rilb_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_EXEC    = 2'd1;
    localparam logic [1:0] S_ADV_RD  = 2'd2;
    localparam logic [1:0] S_ADV_CHK = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = sts.adv_after_exec ? S_ADV_RD : S_IDLE;
                end
            end
            S_ADV_RD:
            begin
                state_next = S_ADV_CHK;
            end
            S_ADV_CHK:
            begin
                if (sts.adv_again)
                begin
                    cmd.adv    = 1'b1;
                    state_next = S_ADV_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* src/rilb_dp.sv */
// Datapath: issue counters, throttle, retry parking, group end table and
// the result register. Driven by rilb_ctrl commands; uses rilb_pkg.
`default_nettype none

module rilb_dp
    import rilb_pkg::*;
#(
    parameter int MAX_GROUPS = 64
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire rilb_cmd_t        cmd,
    output rilb_status_t          sts,
    input  wire [IN_DATA_W-1:0]   s_tdata,
    input  wire [1:0]             s_tuser,
    input  wire [31:0]            total_requests,
    input  wire [15:0]            depth_limit,
    input  wire [15:0]            tick_interval,
    input  wire [GCOUNT_W-1:0]    group_count,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int CG_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CNT_W = ($clog2(MAX_GROUPS + 1) > GCOUNT_W) ?
                           $clog2(MAX_GROUPS + 1) : GCOUNT_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_GROUPS);

    // captured request
    logic [1:0]        op_reg;
    logic              accept_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [31:0]       end_reg;

    // block state
    logic [31:0]     next_index_reg, next_index_next;
    logic [15:0]     in_flight_reg, in_flight_next;
    logic [31:0]     retired_reg, retired_next;
    logic [CG_W-1:0] cg_reg, cg_next;
    logic            retry_reg, retry_next;
    logic [31:0]     parked_reg, parked_next;
    logic [15:0]     ticks_reg, ticks_next;

    logic [31:0] group_mem [MAX_GROUPS];
    logic [31:0] rd_data_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic [CNT_W-1:0] gcount_ext;
    logic [CNT_W-1:0] groups_used;
    logic             cg_has_next;
    logic             gate_ok;
    logic             may_issue;
    logic [15:0]      ticks_inc;
    logic             attempt;
    logic             sent;
    logic [31:0]      sent_idx;
    logic             underflow;
    logic [31:0]      retired_inc;
    logic [15:0]      in_flight_inc;
    logic             slot_fits;

    always_comb
    begin
        gcount_ext  = CNT_W'(group_count);
        groups_used = (gcount_ext > MAX_CNT) ? MAX_CNT : gcount_ext;
        cg_has_next = (CNT_W'(cg_reg) + CNT_W'(1)) < groups_used;
        gate_ok     = (groups_used == '0) || (next_index_reg < rd_data_reg);
        may_issue   = (next_index_reg < total_requests) && !retry_reg &&
                      ((depth_limit == 16'd0) || (in_flight_reg < depth_limit)) &&
                      gate_ok;
        ticks_inc   = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;
        attempt     = (tick_interval == 16'd0) || (ticks_inc >= tick_interval);
        retired_inc = (retired_reg == 32'hFFFF_FFFF) ? retired_reg : retired_reg + 32'd1;
        in_flight_inc = (in_flight_reg == 16'hFFFF) ? in_flight_reg : in_flight_reg + 16'd1;
        slot_fits   = 32'(slot_reg) < 32'(MAX_GROUPS);

        next_index_next = next_index_reg;
        in_flight_next  = in_flight_reg;
        retired_next    = retired_reg;
        retry_next      = retry_reg;
        parked_next     = parked_reg;
        ticks_next      = ticks_reg;
        sent            = 1'b0;
        sent_idx        = 32'd0;
        underflow       = 1'b0;
        sts.adv_after_exec = 1'b0;

        case (op_reg)
            OP_TICK:
            begin
                ticks_next = attempt ? 16'd0 : ticks_inc;
                if (attempt && may_issue)
                begin
                    if (accept_reg)
                    begin
                        sent            = 1'b1;
                        sent_idx        = next_index_reg;
                        next_index_next = next_index_reg + 32'd1;
                        in_flight_next  = in_flight_inc;
                    end
                    else
                    begin
                        retry_next  = 1'b1;
                        parked_next = next_index_reg;
                    end
                end
            end
            OP_RESPONSE:
            begin
                if (in_flight_reg == 16'd0)
                begin
                    underflow = 1'b1;
                end
                else
                begin
                    in_flight_next = in_flight_reg - 16'd1;
                    retired_next   = retired_inc;
                    sts.adv_after_exec = (retired_inc < total_requests) &&
                                         (groups_used != '0) && cg_has_next &&
                                         (retired_inc >= rd_data_reg);
                end
            end
            OP_RETRY:
            begin
                if (retry_reg && accept_reg)
                begin
                    sent            = 1'b1;
                    sent_idx        = parked_reg;
                    retry_next      = 1'b0;
                    next_index_next = next_index_reg + 32'd1;
                    in_flight_next  = in_flight_inc;
                end
            end
            default:
            begin
            end
        endcase

        cg_next = cg_reg;
        if ((cmd.exec && sts.adv_after_exec) || cmd.adv)
        begin
            cg_next = cg_reg + CG_W'(1);
        end

        sts.adv_again = cg_has_next && (retired_reg >= rd_data_reg);
        sts.out_free  = !out_valid_reg || m_tready;

        out_data_next = {4'd0, underflow, (retired_next >= total_requests),
                         in_flight_next, retry_next, sent_idx, sent};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= s_tuser;
            accept_reg <= s_tdata[0];
            slot_reg   <= s_tdata[SLOT_W:1];
            end_reg    <= s_tdata[SLOT_W+32:SLOT_W+1];
        end
        if (cmd.exec)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && (op_reg == OP_LOAD) && slot_fits)
        begin
            group_mem[CG_W'(slot_reg)] <= end_reg;
        end
        rd_data_reg <= group_mem[cg_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_index_reg <= '0;
            in_flight_reg  <= '0;
            retired_reg    <= '0;
            cg_reg         <= '0;
            retry_reg      <= 1'b0;
            parked_reg     <= '0;
            ticks_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                next_index_reg <= next_index_next;
                in_flight_reg  <= in_flight_next;
                retired_reg    <= retired_next;
                retry_reg      <= retry_next;
                parked_reg     <= parked_next;
                ticks_reg      <= ticks_next;
            end
            cg_reg <= cg_next;
            if (cmd.exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
// Testbench for request_issue_limiter_with_barriers. It drives directed and random event
// streams and checks every result against an in-bench model of the issue, park and barrier state.
// Depends on rilb_pkg and the limiter RTL.

module tb;
    import rilb_pkg::*;

    localparam int NUM_SLOTS     = 64;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 2 * NUM_SLOTS + 16;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 120;

    typedef struct {
        logic [1:0] op;
        bit         accept;
        bit [5:0]   slot;
        bit [31:0]  group_end;
    } limiter_req_t;

    typedef struct {
        bit        send_valid;
        bit [31:0] send_index;
        bit        stalled;
        bit [15:0] outstanding_count;
        bit        all_done;
        bit        underflow_error;
    } limiter_result_t;

    class limiter_scoreboard;
        bit [31:0] total_requests;
        bit [15:0] depth_limit;
        bit [15:0] tick_interval;
        bit [6:0]  group_count;
        bit [31:0] next_index;
        bit [15:0] in_flight;
        bit [31:0] retired;
        bit [5:0]  current_group;
        bit [31:0] group_ends [NUM_SLOTS];
        bit        retry_pending;
        bit [31:0] parked_index;
        bit [15:0] ticks_waited;
        limiter_result_t results_due [$];
        int errors, requests_seen, results_checked, sends, parks, underflows, barrier_moves;

        function void write_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_TOTAL:    total_requests = value;
                REG_DEPTH:    depth_limit = value[15:0];
                REG_INTERVAL: tick_interval = value[15:0];
                default:      group_count = value[6:0];
            endcase
        endfunction

        function int groups_in_use();
            return (group_count > NUM_SLOTS) ? NUM_SLOTS : int'(group_count);
        endfunction

        function bit can_issue();
            if (next_index >= total_requests) return 0;
            if (retry_pending) return 0;
            if (depth_limit != 0 && in_flight >= depth_limit) return 0;
            if (groups_in_use() != 0 && next_index >= group_ends[current_group]) return 0;
            return 1;
        endfunction

        function bit [31:0] take_issue(bit [31:0] index);
            next_index++;
            if (in_flight != 16'hFFFF) in_flight++;
            sends++;
            return index;
        endfunction

        function void record_request(limiter_req_t r);
            limiter_result_t e;
            e = '{default: 0};
            requests_seen++;
            case (r.op)
                OP_TICK: begin
                    if (ticks_waited != 16'hFFFF) ticks_waited++;
                    if (tick_interval == 0 || ticks_waited >= tick_interval) begin
                        ticks_waited = 0;
                        if (can_issue()) begin
                            if (r.accept) begin
                                e.send_valid = 1;
                                e.send_index = take_issue(next_index);
                            end
                            else begin
                                retry_pending = 1;
                                parked_index = next_index;
                                parks++;
                            end
                        end
                    end
                end
                OP_RESPONSE: begin
                    if (in_flight == 0) begin
                        e.underflow_error = 1;
                        underflows++;
                    end
                    else begin
                        in_flight--;
                        if (retired != 32'hFFFF_FFFF) retired++;
                        // no barrier movement once the sequence has completed
                        if (retired < total_requests) begin
                            while (int'(current_group) + 1 < groups_in_use() &&
                                   retired >= group_ends[current_group])
                            begin
                                current_group++;
                                barrier_moves++;
                            end
                        end
                    end
                end
                OP_RETRY: begin
                    if (retry_pending && r.accept) begin
                        retry_pending = 0;
                        e.send_valid = 1;
                        e.send_index = take_issue(parked_index);
                    end
                end
                default: group_ends[r.slot] = r.group_end;
            endcase
            e.stalled = retry_pending;
            e.outstanding_count = in_flight;
            e.all_done = (retired >= total_requests);
            results_due = {results_due, e};
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            limiter_result_t want;
            if (results_due.size() == 0) begin
                $error("result 0x%0h with no request pending", data);
                errors++;
                return;
            end
            want = results_due.pop_front();
            results_checked++;
            if ($isunknown(data)) begin
                $error("result has unknown bits: 0x%0h", data);
                errors++;
                return;
            end
            compare_field("send_valid", want.send_valid, data[0]);
            compare_field("send_index", want.send_index, data[32:1]);
            compare_field("stalled", want.stalled, data[33]);
            compare_field("outstanding_count", want.outstanding_count, data[49:34]);
            compare_field("all_done", want.all_done, data[50]);
            compare_field("underflow_error", want.underflow_error, data[51]);
            compare_field("pad", 0, data[55:52]);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = OP_TICK;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    limiter_scoreboard sb = new;
    bit no_idle = 1'b0;
    int results_taken = 0;

    request_issue_limiter_with_barriers uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic limiter_req_t make_request(logic [1:0] op, bit accept, bit [5:0] slot,
                                                  bit [31:0] group_end);
        limiter_req_t r;
        r.op = op;
        r.accept = accept;
        r.slot = slot;
        r.group_end = group_end;
        return r;
    endfunction

    // Mostly well-formed traffic steered by the predicted state, some noise.
    function automatic limiter_req_t random_request();
        limiter_req_t r;
        int pick;
        pick = $urandom_range(0, 99);
        r = make_request(OP_TICK, $urandom_range(0, 99) < 85, 6'($urandom), $urandom);
        if (pick < 8)
            r.op = 2'($urandom_range(0, 3));
        else if (sb.retry_pending)
            r.op = (pick < 65) ? OP_RETRY : ((sb.in_flight != 0) ? OP_RESPONSE : OP_TICK);
        else if (sb.in_flight != 0 && (!sb.can_issue() || pick < 45))
            r.op = OP_RESPONSE;
        return r;
    endfunction

    task automatic send_request(limiter_req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {1'b0, r.group_end, r.slot, r.accept};
        do @(posedge clk); while (!s_tready);
        sb.record_request(r);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limits(bit [31:0] total, bit [15:0] depth, bit [15:0] interval,
                              bit [6:0] groups);
        apb_write(REG_TOTAL, total);
        apb_write(REG_DEPTH, {16'd0, depth});
        apb_write(REG_INTERVAL, {16'd0, interval});
        apb_write(REG_GROUPS, {25'd0, groups});
    endtask

    // Group ends ahead of the next index, some groups empty.
    task automatic load_barriers();
        int last;
        bit [31:0] bound;
        if (sb.groups_in_use() == 0) return;
        last = (sb.groups_in_use() > sb.current_group) ? sb.groups_in_use() - 1
                                                       : int'(sb.current_group);
        bound = sb.next_index + $urandom_range(1, 6);
        for (int g = sb.current_group; g <= last; g++) begin
            send_request(make_request(OP_LOAD, $urandom_range(0, 1), 6'(g), bound));
            bound += $urandom_range(0, 6);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.results_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int gap;
        while (!rst_n) @(posedge clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 16);
            if (results_taken == HOLD_AT) gap = HOLD_CYCLES;
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tdata);
            results_taken++;
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no request moved for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        bit [31:0] total;
        bit [15:0] depth;
        bit [15:0] interval;
        bit [6:0]  groups;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_limits(6, 2, 0, 0);
        for (int g = 0; g < NUM_SLOTS; g++)
            send_request(make_request(OP_LOAD, g[0], 6'(g),
                                      (g == 0) ? 32'd0 :
                                      (g == NUM_SLOTS - 1) ? 32'hFFFF_FFFF : $urandom));

        // underflow, depth limit, refusal and retry handling
        send_request(make_request(OP_RESPONSE, 1, 0, 0));
        repeat (3) send_request(make_request(OP_TICK, 1, 0, 0));
        send_request(make_request(OP_RESPONSE, 0, 0, 0));
        send_request(make_request(OP_TICK, 0, 0, 0));
        send_request(make_request(OP_TICK, 1, 0, 0));
        send_request(make_request(OP_RETRY, 0, 0, 0));
        repeat (2) send_request(make_request(OP_RETRY, 1, 0, 0));
        send_request(make_request(OP_LOAD, 0, 0, 4));
        send_request(make_request(OP_LOAD, 1, 1, 4));
        send_request(make_request(OP_LOAD, 0, 2, 6));
        settle();

        // throttle, barrier hold, advance across an empty group, completion
        set_limits(6, 0, 2, 3);
        repeat (4) send_request(make_request(OP_TICK, 1, 0, 0));
        repeat (3) send_request(make_request(OP_RESPONSE, 0, 0, 0));
        repeat (4) send_request(make_request(OP_TICK, 1, 0, 0));
        repeat (3) send_request(make_request(OP_RESPONSE, 0, 0, 0));
        settle();

        for (int p = 0; p < 14; p++) begin
            total = sb.next_index + $urandom_range(1, 60);
            depth = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
            interval = 16'($urandom_range(0, 4));
            groups = ($urandom_range(0, 2) == 0) ? 7'd0 : 7'($urandom_range(1, 8));
            if (p == 0) begin
                total = 32'hFFFF_FFFF;
                depth = 16'hFFFF;
                interval = 16'hFFFF;
                groups = 7'd64;
            end
            if (p == 1) begin
                total = 0;
                interval = 0;
            end
            if (p == 2) groups = 7'd64;
            set_limits(total, depth, interval, groups);
            load_barriers();
            no_idle = (p == 5);
            repeat ((p == 0) ? 20 : 70) send_request(random_request());
            no_idle = 1'b0;
            settle();
        end

        $display("Ran %0d requests (%0d sends, %0d parked attempts, %0d underflows),",
                 sb.requests_seen, sb.sends, sb.parks, sb.underflows);
        $display("%0d barrier advances, %0d results checked, %0d mismatches.",
                 sb.barrier_moves, sb.results_checked, sb.errors);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
